// File: sv/section_address_translator_core_defines.svh
// Assertion macros shared by the section address translator RTL.
// Used by the top level only; relies on clk and rst_n being in scope.
`ifndef SECTION_ADDRESS_TRANSLATOR_CORE_DEFINES_SVH
`define SECTION_ADDRESS_TRANSLATOR_CORE_DEFINES_SVH

// Same-cycle implication, checked outside reset.
`define SAT_ASSERT_IMPL(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked outside reset.
`define SAT_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: sv/sat_pkg.sv
// Types and request codes for the section address translator.
// No dependencies; used by sat_match and section_address_translator_core.
`timescale 1ns / 1ps
`default_nettype none

package sat_pkg;

    typedef enum logic [1:0] {
        REQ_LOAD        = 2'd0,
        REQ_MEM_TO_FILE = 2'd1,
        REQ_FILE_TO_MEM = 2'd2
    } req_t;

    // One section table entry as stored in the table RAM.
    typedef struct packed {
        logic [31:0] raw_size;
        logic [31:0] raw_base;
        logic [31:0] virt_size;
        logic [31:0] virt_base;
    } section_t;

    typedef struct packed {
        logic        hit;
        logic [31:0] value;
    } match_t;

endpackage

`default_nettype wire

// File: sv/sat_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies; holds the section table.
`timescale 1ns / 1ps
`default_nettype none

module sat_ram #(
    parameter int WIDTH = 128,
    parameter int DEPTH = 16,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic             clk,
    input  wire logic             we,
    input  wire logic [AW-1:0]    waddr,
    input  wire logic [WIDTH-1:0] wdata,
    input  wire logic [AW-1:0]    raddr,
    output logic      [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        rdata_reg <= mem_reg[raddr];
    end

    assign rdata = rdata_reg;

endmodule

`default_nettype wire

// File: sv/sat_match.sv
// Shared range-check and rebase unit: tests one section entry per cycle.
// Depends on sat_pkg for the entry and result types.
`timescale 1ns / 1ps
`default_nettype none

module sat_match (
    input  wire logic [31:0]      addr,
    input  wire logic             to_file,
    input  wire sat_pkg::section_t entry,
    output sat_pkg::match_t       result
);

    logic [31:0] src_base;
    logic [31:0] src_size;
    logic [31:0] dst_base;
    logic [32:0] end_sum;
    logic [31:0] offset;

    always_comb
    begin
        if (to_file)
        begin
            src_base = entry.virt_base;
            src_size = entry.virt_size;
            dst_base = entry.raw_base;
        end
        else
        begin
            src_base = entry.raw_base;
            src_size = entry.raw_size;
            dst_base = entry.virt_base;
        end
        end_sum = {1'b0, src_base} + {1'b0, src_size};
        offset  = addr - src_base;
        // A range whose end wraps past 2^32 can never hold the address.
        result.hit   = !end_sum[32] && (addr >= src_base) && (offset < src_size);
        result.value = offset + dst_base;
    end

endmodule

`default_nettype wire

// File: sv/section_address_translator_core.sv
// Section address translator top level: APB registers, sequencer, table RAM.
// Depends on sat_pkg, sat_ram, sat_match and the assertion macro header.
//
// A load request writes one section entry and gives no result. A translate
// request whose address is at or below header_size, or that meets an empty
// search (section_count of zero), gives its result in the cycle after
// acceptance. Otherwise the sequencer walks the section table in index order
// through the table RAM's single read port, one entry per cycle, feeding the
// shared range-check unit; the search stops with a hit at the first matching
// entry, or with a miss after the last of min(section_count, MAX_SECTIONS)
// entries. The block takes no new request while a search runs. Entries never
// loaded must not be searched.
`timescale 1ns / 1ps
`default_nettype none
`include "section_address_translator_core_defines.svh"

module section_address_translator_core #(
    parameter int MAX_SECTIONS = 16
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    // APB configuration port
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [2:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic      [31:0] prdata,
    output logic             pready,
    // request channel
    input  wire logic        in_valid,
    output logic             in_ready,
    input  wire logic [1:0]  req_type,
    input  wire logic [3:0]  slot,
    input  wire logic [31:0] sec_virtual_base,
    input  wire logic [31:0] sec_virtual_size,
    input  wire logic [31:0] sec_raw_base,
    input  wire logic [31:0] sec_raw_size,
    input  wire logic [31:0] address,
    // result channel
    output logic             out_valid,
    input  wire logic        out_ready,
    output logic [31:0]      translated,
    output logic             hit
);

    localparam int IDX_W = (MAX_SECTIONS > 1) ? $clog2(MAX_SECTIONS) : 1;
    localparam int CNT_W = $clog2(MAX_SECTIONS + 1);

    localparam logic REG_HEADER = 1'b0;
    localparam logic REG_COUNT  = 1'b1;

    typedef enum logic [1:0] {
        S_IDLE = 2'b01,
        S_SCAN = 2'b10
    } state_t;

    state_t             state_reg, state_next;
    logic [31:0]        header_size_reg;
    logic [4:0]         section_count_reg;
    logic [31:0]        addr_reg, addr_next;
    logic               to_file_reg, to_file_next;
    logic [CNT_W-1:0]   lim_reg, lim_next;
    logic [CNT_W-1:0]   rd_idx_reg, rd_idx_next;
    logic [CNT_W-1:0]   chk_idx_reg, chk_idx_next;
    logic               chk_valid_reg, chk_valid_next;
    logic               out_valid_reg, out_valid_next;
    logic [31:0]        translated_reg, translated_next;
    logic               hit_reg, hit_next;

    logic               cfg_write;
    logic               in_fire;
    logic               is_load;
    logic               is_xlate;
    logic [CNT_W-1:0]   lim_now;
    logic               issue;
    logic               chk_last;
    logic               ram_we;
    sat_pkg::section_t  wr_entry;
    sat_pkg::section_t  rd_entry;
    sat_pkg::match_t    match;

    // ---------------- configuration registers ----------------
    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            header_size_reg   <= '0;
            section_count_reg <= '0;
        end
        else if (cfg_write)
        begin
            unique case (paddr[2])
                REG_HEADER: header_size_reg   <= pwdata;
                REG_COUNT:  section_count_reg <= pwdata[4:0];
                default:    header_size_reg   <= header_size_reg;
            endcase
        end
    end

    always_comb
    begin
        unique case (paddr[2])
            REG_HEADER: prdata = header_size_reg;
            REG_COUNT:  prdata = {27'd0, section_count_reg};
            default:    prdata = '0;
        endcase
    end

    // ---------------- section table ----------------
    assign is_load  = (req_type == sat_pkg::REQ_LOAD);
    assign is_xlate = (req_type == sat_pkg::REQ_MEM_TO_FILE)
                   || (req_type == sat_pkg::REQ_FILE_TO_MEM);
    assign in_ready = (state_reg == S_IDLE) && (!out_valid_reg || out_ready);
    assign in_fire  = in_valid && in_ready;
    // Drop loads aimed past the table.
    assign ram_we   = in_fire && is_load && (32'(slot) < 32'(MAX_SECTIONS));

    assign wr_entry.virt_base = sec_virtual_base;
    assign wr_entry.virt_size = sec_virtual_size;
    assign wr_entry.raw_base  = sec_raw_base;
    assign wr_entry.raw_size  = sec_raw_size;

    sat_ram #(
        .WIDTH ($bits(sat_pkg::section_t)),
        .DEPTH (MAX_SECTIONS),
        .AW    (IDX_W)
    ) u_table (
        .clk   (clk),
        .we    (ram_we),
        .waddr (IDX_W'(slot)),
        .wdata (wr_entry),
        .raddr (rd_idx_reg[IDX_W-1:0]),
        .rdata (rd_entry)
    );

    sat_match u_match (
        .addr    (addr_reg),
        .to_file (to_file_reg),
        .entry   (rd_entry),
        .result  (match)
    );

    // ---------------- sequencer ----------------
    always_comb
    begin
        if (32'(section_count_reg) > 32'(MAX_SECTIONS))
        begin
            lim_now = CNT_W'(MAX_SECTIONS);
        end
        else
        begin
            lim_now = CNT_W'(section_count_reg);
        end
    end

    assign issue    = rd_idx_reg < lim_reg;
    assign chk_last = (CNT_W'(chk_idx_reg + CNT_W'(1)) == lim_reg);

    always_comb
    begin
        state_next      = state_reg;
        addr_next       = addr_reg;
        to_file_next    = to_file_reg;
        lim_next        = lim_reg;
        rd_idx_next     = rd_idx_reg;
        chk_idx_next    = chk_idx_reg;
        chk_valid_next  = 1'b0;
        out_valid_next  = out_valid_reg && !out_ready;
        translated_next = translated_reg;
        hit_next        = hit_reg;

        unique case (state_reg)
            S_IDLE:
            begin
                if (in_fire && is_xlate)
                begin
                    addr_next    = address;
                    to_file_next = (req_type == sat_pkg::REQ_MEM_TO_FILE);
                    lim_next     = lim_now;
                    rd_idx_next  = '0;
                    if (address <= header_size_reg)
                    begin
                        out_valid_next  = 1'b1;
                        translated_next = address;
                        hit_next        = 1'b1;
                    end
                    else if (lim_now == '0)
                    begin
                        out_valid_next  = 1'b1;
                        translated_next = '0;
                        hit_next        = 1'b0;
                    end
                    else
                    begin
                        state_next = S_SCAN;
                    end
                end
            end
            S_SCAN:
            begin
                if (chk_valid_reg && match.hit)
                begin
                    out_valid_next  = 1'b1;
                    translated_next = match.value;
                    hit_next        = 1'b1;
                    state_next      = S_IDLE;
                end
                else if (chk_valid_reg && chk_last)
                begin
                    out_valid_next  = 1'b1;
                    translated_next = '0;
                    hit_next        = 1'b0;
                    state_next      = S_IDLE;
                end
                else
                begin
                    // Advance the read pointer; its data is checked next cycle.
                    chk_valid_next = issue;
                    chk_idx_next   = rd_idx_reg;
                    if (issue)
                    begin
                        rd_idx_next = CNT_W'(rd_idx_reg + CNT_W'(1));
                    end
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            chk_valid_reg <= 1'b0;
            out_valid_reg <= 1'b0;
            rd_idx_reg    <= '0;
            lim_reg       <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            chk_valid_reg <= chk_valid_next;
            out_valid_reg <= out_valid_next;
            rd_idx_reg    <= rd_idx_next;
            lim_reg       <= lim_next;
        end
    end

    always_ff @(posedge clk)
    begin
        addr_reg       <= addr_next;
        to_file_reg    <= to_file_next;
        chk_idx_reg    <= chk_idx_next;
        translated_reg <= translated_next;
        hit_reg        <= hit_next;
    end

    assign out_valid  = out_valid_reg;
    assign translated = translated_reg;
    assign hit        = hit_reg;

    // ---------------- assertions ----------------
    `SAT_ASSERT_IMPL(a_scan_blocks_input, state_reg == S_SCAN, !in_ready, "request taken during search")
    `SAT_ASSERT_IMPL(a_scan_no_result, state_reg == S_SCAN, !out_valid_reg, "result pending during search")
    `SAT_ASSERT_IMPL(a_ptr_in_range, state_reg == S_SCAN, rd_idx_reg <= lim_reg, "read pointer past limit")
    `SAT_ASSERT_IMPL(a_miss_is_zero, out_valid_reg && !hit_reg, translated_reg == 32'd0, "miss with nonzero value")

endmodule

`default_nettype wire
